>>> hdl/nmea_pkg.sv
package nmea_pkg;

   localparam int NMEA_LINE_BYTES = 128;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   localparam logic [39:0] GGA_TAG = "GPGGA";
   localparam logic [39:0] RMC_TAG = "GPRMC";

   localparam logic [6:0] MAX_LENGTH_RESET = 7'd127;

   localparam logic [2:0] STATUS_GGA    = 3'd0;
   localparam logic [2:0] STATUS_RMC    = 3'd1;
   localparam logic [2:0] STATUS_OTHER  = 3'd2;
   localparam logic [2:0] STATUS_CKERR  = 3'd3;
   localparam logic [2:0] STATUS_LONG   = 3'd4;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_BODY,
      PH_HEX,
      PH_TAIL_OK,
      PH_TAIL_BAD
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  running_xor;
      logic [7:0]  hex_value;
      logic        hex_seen;
      logic [6:0]  char_count;
      logic [1:0]  type_match;   // bit 0 GGA, bit 1 RMC
      logic [31:0] good_total;
      logic [31:0] bad_total;
   } parse_state_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [6:0]  length;
      logic [7:0]  computed_sum;
      logic [7:0]  received_sum;
      logic [31:0] accepted_count;
      logic [31:0] error_count;
   } parse_result_type;

   // tag character at sentence position 1..5
   function automatic logic [7:0] tag_char(logic [39:0] tag, logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd1:    c = tag[39:32];
         3'd2:    c = tag[31:24];
         3'd3:    c = tag[23:16];
         3'd4:    c = tag[15:8];
         3'd5:    c = tag[7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // {valid, digit}
   function automatic logic [4:0] hex_decode(logic [7:0] b);
      logic [4:0] r;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

endpackage

>>> hdl/nmea_sentence_checker.sv
// Path: a byte accepted into the input register is parsed combinationally,
// and a result it closes is captured in the result register, which drives
// rsp_valid; a stalled result holds the parse stage back.
// Throughput: one byte per cycle unless rsp_stall holds a pending result;
// the parse state is updated per byte between input and result registers.
// Reset (synchronous): hunting for '$', sums and totals cleared, max_length 127.
module nmea_sentence_checker
   import nmea_pkg::*;
#(
   parameter int LINE_BYTES = NMEA_LINE_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_sentence_length,
   output logic [7:0]  rsp_computed_sum,
   output logic [7:0]  rsp_received_sum,
   output logic [31:0] rsp_accepted_count,
   output logic [31:0] rsp_error_count
);

   localparam logic [6:0] LIMIT_CAP = 7'(LINE_BYTES - 1);

   localparam parse_state_type STATE_RESET = '{
      phase:       PH_HUNT,
      running_xor: 8'h00,
      hex_value:   8'h00,
      hex_seen:    1'b0,
      char_count:  7'd0,
      type_match:  2'b11,
      good_total:  32'd0,
      bad_total:   32'd0
   };

   logic [6:0]       max_length_ff;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   parse_state_type  state_ff;
   parse_state_type  state_in;
   parse_result_type result_in;
   parse_result_type result_ff;
   logic             rsp_valid_ff;
   logic [6:0]       limit;
   logic             advance;

   assign limit     = (max_length_ff < LIMIT_CAP) ? max_length_ff : LIMIT_CAP;
   // the parse stage moves only when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   nmea_parse u_parse (
      .rx_byte (in_byte_ff),
      .limit   (limit),
      .cur     (state_ff),
      .nxt     (state_in),
      .res     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_wr_en) begin
         max_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result_in.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result word while stalled
   always_ff @(posedge clock) begin
      if (advance && result_in.valid) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = result_ff.status;
   assign rsp_sentence_length = result_ff.length;
   assign rsp_computed_sum    = result_ff.computed_sum;
   assign rsp_received_sum    = result_ff.received_sum;
   assign rsp_accepted_count  = result_ff.accepted_count;
   assign rsp_error_count     = result_ff.error_count;

endmodule

>>> hdl/nmea_parse.sv
module nmea_parse
   import nmea_pkg::*;
(
   input  logic [7:0]       rx_byte,
   input  logic [6:0]       limit,
   input  parse_state_type  cur,
   output parse_state_type  nxt,
   output parse_result_type res
);

   logic [2:0] pos3;
   logic [4:0] hex;
   logic       ok;
   logic       stored;

   always_comb begin
      nxt    = cur;
      res    = '0;
      ok     = 1'b0;
      stored = 1'b0;
      pos3   = 3'd0;
      hex    = hex_decode(rx_byte);

      if (cur.phase == PH_HUNT) begin
         if (rx_byte == CHAR_DOLLAR) begin
            nxt.phase       = PH_BODY;
            nxt.running_xor = 8'h00;
            nxt.hex_value   = 8'h00;
            nxt.hex_seen    = 1'b0;
            nxt.type_match  = 2'b11;
            nxt.char_count  = (limit >= 7'd1) ? 7'd1 : 7'd0;
         end
      end else begin
         stored = cur.char_count < limit;
         if (stored) begin
            nxt.char_count = cur.char_count + 7'd1;
            if (rx_byte != CHAR_LF) begin
               // type tag sits at positions 1..5
               if (cur.char_count >= 7'd1 && cur.char_count <= 7'd5) begin
                  pos3 = cur.char_count[2:0];
                  if (rx_byte != tag_char(GGA_TAG, pos3)) nxt.type_match[0] = 1'b0;
                  if (rx_byte != tag_char(RMC_TAG, pos3)) nxt.type_match[1] = 1'b0;
               end
               case (cur.phase)
                  PH_BODY: begin
                     if (rx_byte == CHAR_STAR) nxt.phase = PH_HEX;
                     else nxt.running_xor = cur.running_xor ^ rx_byte;
                  end
                  PH_HEX: begin
                     if (hex[4]) begin
                        nxt.hex_value = {cur.hex_value[3:0], hex[3:0]};
                        nxt.hex_seen  = 1'b1;
                     end else if ((rx_byte == CHAR_CR) && cur.hex_seen) begin
                        nxt.phase = PH_TAIL_OK;
                     end else begin
                        nxt.phase = PH_TAIL_BAD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         if (rx_byte == CHAR_LF) begin
            if (nxt.phase == PH_TAIL_OK || (nxt.phase == PH_HEX && nxt.hex_seen))
               ok = (nxt.running_xor == nxt.hex_value);
            res.valid = 1'b1;
            if (ok) begin
               nxt.good_total = cur.good_total + 32'd1;
               if (nxt.type_match[0])      res.status = STATUS_GGA;
               else if (nxt.type_match[1]) res.status = STATUS_RMC;
               else                        res.status = STATUS_OTHER;
            end else begin
               nxt.bad_total = cur.bad_total + 32'd1;
               res.status    = STATUS_CKERR;
            end
            nxt.phase = PH_HUNT;
         end else if (nxt.char_count >= limit) begin
            // drop overlong sentence, resume hunting
            res.valid  = 1'b1;
            res.status = STATUS_LONG;
            nxt.phase  = PH_HUNT;
         end
      end

      res.length         = nxt.char_count;
      res.computed_sum   = nxt.running_xor;
      res.received_sum   = nxt.hex_value;
      res.accepted_count = nxt.good_total;
      res.error_count    = nxt.bad_total;
   end

endmodule
